// ===== src/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int PRIO_W    = 32;
    localparam int DATA_W    = 16;
    localparam int COUNT_W   = 5;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== src/spq_ctrl.sv =====
`default_nettype none

module spq_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output spq_pkg::dp_cmd_t     cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            spq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = spq_pkg::ST_EXEC;
                end
            end
            spq_pkg::ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = spq_pkg::ST_RESP;
            end
            spq_pkg::ST_RESP: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/spq_datapath.sv =====
`default_nettype none

module spq_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire spq_pkg::dp_cmd_t               cmd,
    input  wire logic [spq_pkg::KIND_W-1:0]     in_kind,
    input  wire logic [spq_pkg::PRIO_W-1:0]     in_priority,
    input  wire logic [spq_pkg::DATA_W-1:0]     in_data,
    output logic [spq_pkg::STATUS_W-1:0]        status,
    output logic [spq_pkg::DATA_W-1:0]          front_data,
    output logic [spq_pkg::PRIO_W-1:0]          front_priority,
    output logic [spq_pkg::COUNT_W-1:0]         count,
    output logic                                is_full,
    output logic                                is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_pkg::kind_t                   kind_reg;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg;
    logic [spq_pkg::DATA_W-1:0]       data_reg;

    logic signed [spq_pkg::PRIO_W-1:0] prio_cell_reg  [CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] prio_cell_next [CAPACITY];
    logic [spq_pkg::DATA_W-1:0]        data_cell_reg  [CAPACITY];
    logic [spq_pkg::DATA_W-1:0]        data_cell_next [CAPACITY];

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    spq_pkg::status_t            status_reg;
    spq_pkg::status_t            status_next;

    logic [CAPACITY-1:0]         take;
    logic                        full;
    logic                        empty;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= spq_pkg::kind_t'(in_kind);
            prio_reg <= in_priority;
            data_reg <= in_data;
        end
    end

    // take[i]: the new entry lands at or before cell i; monotone over the row
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            assign take[i] = (CNT_W'(i) >= count_reg) || (prio_reg < prio_cell_reg[i]);

            always_comb begin
                prio_cell_next[i] = prio_cell_reg[i];
                data_cell_next[i] = data_cell_reg[i];
                case (kind_reg)
                    spq_pkg::KIND_INSERT: begin
                        if (!full && take[i]) begin
                            if (i == 0) begin
                                prio_cell_next[i] = prio_reg;
                                data_cell_next[i] = data_reg;
                            end else if (take[(i > 0) ? i - 1 : 0]) begin
                                prio_cell_next[i] = prio_cell_reg[(i > 0) ? i - 1 : 0];
                                data_cell_next[i] = data_cell_reg[(i > 0) ? i - 1 : 0];
                            end else begin
                                prio_cell_next[i] = prio_reg;
                                data_cell_next[i] = data_reg;
                            end
                        end
                    end
                    spq_pkg::KIND_REMOVE: begin
                        if (!empty && (i < CAPACITY - 1)) begin
                            prio_cell_next[i] =
                                prio_cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
                            data_cell_next[i] =
                                data_cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
                        end
                    end
                    default: begin
                    end
                endcase
            end

            always_ff @(posedge aclk) begin
                if (cmd.execute) begin
                    prio_cell_reg[i] <= prio_cell_next[i];
                    data_cell_reg[i] <= data_cell_next[i];
                end
            end
        end
    endgenerate

    always_comb begin
        count_next  = count_reg;
        status_next = spq_pkg::STATUS_OK;
        case (kind_reg)
            spq_pkg::KIND_INSERT: begin
                if (full) begin
                    status_next = spq_pkg::STATUS_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            spq_pkg::KIND_REMOVE: begin
                if (empty) begin
                    status_next = spq_pkg::STATUS_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            spq_pkg::KIND_PEEK: begin
                if (empty) begin
                    status_next = spq_pkg::STATUS_EMPTY;
                end
            end
            default: begin
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.execute) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            status_reg <= status_next;
        end
    end

    assign status         = status_reg;
    assign front_data     = empty ? '0 : data_cell_reg[0];
    assign front_priority = empty ? '0 : prio_cell_reg[0];
    assign count          = spq_pkg::COUNT_W'(count_reg);
    assign is_full        = full;
    assign is_empty       = empty;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && kind_reg == spq_pkg::KIND_INSERT && !full)
        |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("accepted insert did not add an entry");

    a_front_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (prio_cell_reg[0] <= prio_cell_reg[1]))
        else $error("front cells out of priority order");

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue_top.sv =====
// Bounded priority queue of CAPACITY entries, each a signed Q16.16 priority and a
// 16-bit tag, held in a row of cells sorted smallest priority first; equal priorities
// leave in arrival order. Each input transfer carries one operation in s_tuser (insert,
// remove front, peek, clear) and yields exactly one result transfer with the status,
// the front entry (zero when empty), the count and the full and empty flags, all as
// they stand after the operation. An insert into a full queue is dropped with status
// full; remove or peek on an empty queue returns status empty. Each item passes through
// three steps: one to capture the request, one in which every cell compares against
// the new priority in parallel and shifts or loads, and one to present the result; a
// stalled result holds off the next input transfer.
`default_nettype none

module sorted_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,  // priority_req, entry_data
    input  wire logic [spq_pkg::KIND_W-1:0]      s_tuser,  // kind
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status, front_data, front_priority, count, is_full, is_empty, zero fill
    output logic [spq_pkg::M_TDATA_W-1:0]        m_tdata
);

    spq_pkg::dp_cmd_t                   cmd;
    logic [spq_pkg::STATUS_W-1:0]       status;
    logic [spq_pkg::DATA_W-1:0]         front_data;
    logic [spq_pkg::PRIO_W-1:0]         front_priority;
    logic [spq_pkg::COUNT_W-1:0]        count;
    logic                               is_full;
    logic                               is_empty;

    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_kind        (s_tuser),
        .in_priority    (s_tdata[spq_pkg::PRIO_W-1:0]),
        .in_data        (s_tdata[spq_pkg::PRIO_W +: spq_pkg::DATA_W]),
        .status         (status),
        .front_data     (front_data),
        .front_priority (front_priority),
        .count          (count),
        .is_full        (is_full),
        .is_empty       (is_empty)
    );

    assign m_tdata = {7'd0, is_empty, is_full, count, front_priority, front_data, status};

endmodule

`default_nettype wire
